// File: rtl/core/kwsc_pkg.sv
// ----------------------------------------------------------------------------
// kwsc_pkg
// shared types and constants for the keyword substitution cipher
// ----------------------------------------------------------------------------
package kwsc_pkg;

    localparam int unsigned ALPHA_LEN  = 26;
    localparam int unsigned LETTER_W   = 5;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [7:0] LETTER_A = 8'd65;
    localparam logic [7:0] LETTER_Z = 8'd90;
    localparam logic [7:0] LOWER_A  = 8'd97;
    localparam logic [7:0] LOWER_Z  = 8'd122;

    localparam logic [LETTER_W-1:0] LAST_LETTER        = LETTER_W'(ALPHA_LEN - 1);
    localparam logic [LETTER_W-1:0] ALPHA_COUNT        = LETTER_W'(ALPHA_LEN);
    localparam logic [LETTER_W-1:0] MIN_DISTINCT_RESET = 5'd8;

    // register index, taken from paddr[2]
    localparam logic REG_MIN_DISTINCT = 1'b0;

    typedef logic [LETTER_W-1:0] letter_t;

    typedef enum logic [1:0] {
        REQ_KEY_CHAR = 2'd0,
        REQ_KEY_END  = 2'd1,
        REQ_PLAIN    = 2'd2,
        REQ_CLEAR    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_KEY_INVALID = 2'd1,
        STATUS_NO_KEY      = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_FILL
    } state_t;

    typedef struct packed {
        logic exec;
        logic fill_init;
        logic fill_step;
        logic fill_finish;
    } kwsc_cmd_t;

    typedef struct packed {
        logic key_ready;
        logic fill_last;
    } kwsc_stat_t;

endpackage

// File: rtl/core/keyword_substitution_cipher.sv
// ----------------------------------------------------------------------------
// keyword_substitution_cipher
// keyword cipher with a keyed alphabet built from a streamed key
// ----------------------------------------------------------------------------
// An item is taken on start while busy is low. Key characters, plaintext
// characters, clear-key requests and a repeated key end are each handled at
// once with busy left low, so a new item can follow in the next cycle; a
// result appears on result_valid, char_out and status in the cycle after the
// item is taken and lasts that one cycle only, with no way for the receiver to
// stall it. The first key end after a key walks all 26 letters through the
// fill sequencer, one letter a cycle, to append the unused letters to the
// keyed alphabet: busy is high while the walk runs, the status result is
// shown in the cycle that busy falls, and the next item can be taken in that
// same cycle.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher
    import kwsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            req_type,
    input  logic [7:0]            char_in,
    output logic                  result_valid,
    output logic [7:0]            char_out,
    output logic [1:0]            status,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    kwsc_cmd_t  cmd;
    kwsc_stat_t stat;
    letter_t    min_distinct;

    kwsc_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .min_distinct (min_distinct)
    );

    kwsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    kwsc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .req_type     (req_type),
        .char_in      (char_in),
        .min_distinct (min_distinct),
        .stat         (stat),
        .result_valid (result_valid),
        .char_out     (char_out),
        .status       (status)
    );

endmodule

// File: rtl/core/kwsc_regs.sv
// ----------------------------------------------------------------------------
// kwsc_regs
// apb configuration register: minimum distinct key letters
// ----------------------------------------------------------------------------
module kwsc_regs
    import kwsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output letter_t               min_distinct
);

    letter_t min_distinct_reg;
    letter_t min_distinct_next;
    logic    hit;

    assign hit    = (paddr[2] == REG_MIN_DISTINCT);
    assign pready = 1'b1;

    always_comb
    begin
        min_distinct_next = min_distinct_reg;
        if (psel && penable && pwrite && hit)
        begin
            min_distinct_next = pwdata[LETTER_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_distinct_reg <= MIN_DISTINCT_RESET;
        end
        else
        begin
            min_distinct_reg <= min_distinct_next;
        end
    end

    assign prdata       = hit ? {{(CFG_DATA_W-LETTER_W){1'b0}}, min_distinct_reg} : '0;
    assign min_distinct = min_distinct_reg;

endmodule

// File: rtl/core/kwsc_ctrl.sv
// ----------------------------------------------------------------------------
// kwsc_ctrl
// controller: request execution and the keyed alphabet fill walk
// ----------------------------------------------------------------------------
module kwsc_ctrl
    import kwsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] req_type,
    input  kwsc_stat_t stat,
    output kwsc_cmd_t  cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if ((req_type == REQ_KEY_END) && !stat.key_ready)
                    begin
                        cmd.fill_init = 1'b1;
                        state_next    = ST_FILL;
                    end
                    else
                    begin
                        cmd.exec = 1'b1;
                    end
                end
            end
            ST_FILL:
            begin
                busy          = 1'b1;
                cmd.fill_step = 1'b1;
                if (stat.fill_last)
                begin
                    cmd.fill_finish = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/kwsc_dp.sv
// ----------------------------------------------------------------------------
// kwsc_dp
// datapath: seen map, letter count, keyed alphabet table, result register
// ----------------------------------------------------------------------------
module kwsc_dp
    import kwsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  kwsc_cmd_t  cmd,
    input  logic [1:0] req_type,
    input  logic [7:0] char_in,
    input  letter_t    min_distinct,
    output kwsc_stat_t stat,
    output logic       result_valid,
    output logic [7:0] char_out,
    output logic [1:0] status
);

    logic [ALPHA_LEN-1:0] seen_reg;
    logic [ALPHA_LEN-1:0] seen_next;
    letter_t              count_reg;
    letter_t              count_next;
    logic                 key_ready_reg;
    logic                 key_ready_next;
    logic                 key_valid_reg;
    logic                 key_valid_next;
    letter_t              fill_idx_reg;
    letter_t              fill_idx_next;
    letter_t              pos_reg;
    letter_t              pos_next;
    letter_t              table_reg [ALPHA_LEN];

    logic                 result_valid_reg;
    logic                 result_valid_next;
    logic [7:0]           char_out_reg;
    logic [7:0]           char_out_next;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;

    logic                 wr_en;
    letter_t              wr_addr;
    letter_t              wr_data;

    logic                 is_lower;
    logic                 is_upper;
    logic [7:0]           lower_off;
    logic [7:0]           upper_off;
    letter_t              key_idx;
    logic [ALPHA_LEN-1:0] seen_eff;
    letter_t              count_eff;
    letter_t              sub_letter;

    assign is_lower  = (char_in >= LOWER_A) && (char_in <= LOWER_Z);
    assign is_upper  = (char_in >= LETTER_A) && (char_in <= LETTER_Z);
    assign lower_off = char_in - LOWER_A;
    assign upper_off = char_in - LETTER_A;
    assign key_idx   = is_lower ? lower_off[LETTER_W-1:0] : upper_off[LETTER_W-1:0];

    // a key character after key end starts a new key
    assign seen_eff   = key_ready_reg ? '0 : seen_reg;
    assign count_eff  = key_ready_reg ? '0 : count_reg;
    assign sub_letter = table_reg[upper_off[LETTER_W-1:0]];

    always_comb
    begin
        seen_next         = seen_reg;
        count_next        = count_reg;
        key_ready_next    = key_ready_reg;
        key_valid_next    = key_valid_reg;
        fill_idx_next     = fill_idx_reg;
        pos_next          = pos_reg;
        result_valid_next = 1'b0;
        char_out_next     = char_out_reg;
        status_next       = status_reg;
        wr_en             = 1'b0;
        wr_addr           = count_eff;
        wr_data           = key_idx;

        if (cmd.exec)
        begin
            case (req_type)
                REQ_KEY_CHAR:
                begin
                    seen_next      = seen_eff;
                    count_next     = count_eff;
                    key_ready_next = 1'b0;
                    key_valid_next = key_ready_reg ? 1'b0 : key_valid_reg;
                    if ((is_lower || is_upper) && !seen_eff[key_idx]
                        && (count_eff < ALPHA_COUNT))
                    begin
                        seen_next[key_idx] = 1'b1;
                        count_next         = count_eff + 1'b1;
                        wr_en              = 1'b1;
                    end
                end
                REQ_KEY_END:
                begin
                    // only reached with a finalized key
                    result_valid_next = 1'b1;
                    char_out_next     = '0;
                    status_next       = key_valid_reg ? STATUS_OK : STATUS_KEY_INVALID;
                end
                REQ_PLAIN:
                begin
                    result_valid_next = 1'b1;
                    if (!key_ready_reg)
                    begin
                        char_out_next = '0;
                        status_next   = STATUS_NO_KEY;
                    end
                    else if (!key_valid_reg)
                    begin
                        char_out_next = '0;
                        status_next   = STATUS_KEY_INVALID;
                    end
                    else
                    begin
                        char_out_next = is_upper
                            ? (LETTER_A + {{(8-LETTER_W){1'b0}}, sub_letter}) : char_in;
                        status_next   = STATUS_OK;
                    end
                end
                REQ_CLEAR:
                begin
                    seen_next      = '0;
                    count_next     = '0;
                    key_ready_next = 1'b0;
                    key_valid_next = 1'b0;
                end
                default:
                begin
                    seen_next = seen_reg;
                end
            endcase
        end

        if (cmd.fill_init)
        begin
            fill_idx_next = '0;
            pos_next      = count_reg;
        end

        if (cmd.fill_step)
        begin
            fill_idx_next = fill_idx_reg + 1'b1;
            if (!seen_reg[fill_idx_reg] && (pos_reg < ALPHA_COUNT))
            begin
                wr_en    = 1'b1;
                wr_addr  = pos_reg;
                wr_data  = fill_idx_reg;
                pos_next = pos_reg + 1'b1;
            end
        end

        if (cmd.fill_finish)
        begin
            key_ready_next    = 1'b1;
            key_valid_next    = (count_reg >= min_distinct);
            result_valid_next = 1'b1;
            char_out_next     = '0;
            status_next       = (count_reg >= min_distinct) ? STATUS_OK : STATUS_KEY_INVALID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg         <= '0;
            count_reg        <= '0;
            key_ready_reg    <= 1'b0;
            key_valid_reg    <= 1'b0;
            fill_idx_reg     <= '0;
            pos_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg         <= seen_next;
            count_reg        <= count_next;
            key_ready_reg    <= key_ready_next;
            key_valid_reg    <= key_valid_next;
            fill_idx_reg     <= fill_idx_next;
            pos_reg          <= pos_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_out_reg <= char_out_next;
        status_reg   <= status_next;
        if (wr_en)
        begin
            table_reg[wr_addr] <= wr_data;
        end
    end

    assign stat.key_ready = key_ready_reg;
    assign stat.fill_last = (fill_idx_reg == LAST_LETTER);

    assign result_valid = result_valid_reg;
    assign char_out     = char_out_reg;
    assign status       = status_reg;

endmodule

// File: rtl/core/kwsc_checker.sv
// ----------------------------------------------------------------------------
// kwsc_checker
// port-level checks for the keyword substitution cipher
// ----------------------------------------------------------------------------
module kwsc_checker
    import kwsc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] req_type,
    input logic       result_valid,
    input logic [7:0] char_out,
    input logic [1:0] status
);

    // every plaintext item answers in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_PLAIN)) |=> result_valid)
        else $error("plaintext item gave no result");

    // key characters and clear requests never answer
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ((req_type == REQ_KEY_CHAR) || (req_type == REQ_CLEAR)))
        |=> !result_valid)
        else $error("result without a request that gives one");

    // results with an error status carry a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != STATUS_OK)) |-> (char_out == 8'd0))
        else $error("nonzero byte on an error status");

    // the fill walk only starts from a key end
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && (req_type == REQ_KEY_END)))
        else $error("busy without a key end");

    // the fill result comes as busy drops
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("fill ended without a result");

endmodule

bind keyword_substitution_cipher kwsc_checker u_kwsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .result_valid (result_valid),
    .char_out     (char_out),
    .status       (status)
);

// File: verif/tb_keyword_substitution_cipher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyword_substitution_cipher
// self-checking testbench for the keyword substitution cipher
// ----------------------------------------------------------------------------
// Streams keys, key ends, plaintext and clear requests into the block through
// the start/busy handshake and predicts every status and cipher byte with its
// own model of the keyed alphabet. A short directed run covers the corner
// cases, then random key/encipher sequences with noise run under several
// min_distinct settings (0, 31 and 26 among them) and three sender idle mixes.
// Results are checked in order as they are strobed out; the register is
// written and read back over APB only while the block is idle.
// ----------------------------------------------------------------------------
module tb_keyword_substitution_cipher;
    import kwsc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned TAIL_CYCLES    = 40;
    localparam int unsigned PHASE_ITEMS    = 130;
    localparam logic [CFG_ADDR_W-1:0] MIN_DISTINCT_ADDR = {REG_MIN_DISTINCT, 2'b00};

    typedef struct packed {
        logic [7:0] char_val;
        status_t    status_val;
    } cipher_out_t;

    class cipher_scoreboard;
        letter_t     subst_alphabet[ALPHA_LEN];
        bit          letter_used[ALPHA_LEN];
        int unsigned key_letters;
        bit          key_closed;
        bit          key_good;
        logic [4:0]  min_distinct;
        cipher_out_t expected_q[$];
        int unsigned error_count;

        function new();
            foreach (subst_alphabet[i])
                subst_alphabet[i] = '0;
            min_distinct = MIN_DISTINCT_RESET;
            error_count  = 0;
            clear_key();
        endfunction

        function void clear_key();
            foreach (letter_used[i])
                letter_used[i] = 1'b0;
            key_letters = 0;
            key_closed  = 1'b0;
            key_good    = 1'b0;
        endfunction

        // folds lower case onto upper case, index 0..25 for letters
        function bit fold_letter(input logic [7:0] c, output int unsigned idx);
            logic [7:0] u;
            u   = (c >= LOWER_A && c <= LOWER_Z) ? c - 8'd32 : c;
            idx = u - LETTER_A;
            return (u >= LETTER_A && u <= LETTER_Z);
        endfunction

        function void write_register(input logic [CFG_ADDR_W-1:0] addr,
                                     input logic [CFG_DATA_W-1:0] data);
            if (addr[2] == REG_MIN_DISTINCT)
                min_distinct = data[4:0];
        endfunction

        function void take_item(input req_t req, input logic [7:0] c);
            cipher_out_t r;
            int unsigned idx;
            int unsigned pos;
            case (req)
                REQ_KEY_CHAR:
                begin
                    if (key_closed)
                        clear_key();
                    if (fold_letter(c, idx) && !letter_used[idx] && key_letters < ALPHA_LEN)
                    begin
                        letter_used[idx]            = 1'b1;
                        subst_alphabet[key_letters] = letter_t'(idx);
                        key_letters++;
                    end
                end
                REQ_KEY_END:
                begin
                    if (!key_closed)
                    begin
                        pos = key_letters;
                        for (int unsigned i = 0; i < ALPHA_LEN; i++)
                        begin
                            if (!letter_used[i] && pos < ALPHA_LEN)
                            begin
                                subst_alphabet[pos] = letter_t'(i);
                                pos++;
                            end
                        end
                        key_closed = 1'b1;
                        key_good   = (key_letters >= min_distinct);
                    end
                    r.char_val   = '0;
                    r.status_val = key_good ? STATUS_OK : STATUS_KEY_INVALID;
                    expected_q.push_back(r);
                end
                REQ_PLAIN:
                begin
                    r.char_val = '0;
                    if (!key_closed)
                        r.status_val = STATUS_NO_KEY;
                    else if (!key_good)
                        r.status_val = STATUS_KEY_INVALID;
                    else
                    begin
                        r.status_val = STATUS_OK;
                        if (c >= LETTER_A && c <= LETTER_Z)
                            r.char_val = LETTER_A + 8'(subst_alphabet[c - LETTER_A]);
                        else
                            r.char_val = c;
                    end
                    expected_q.push_back(r);
                end
                default:
                    clear_key();
            endcase
        endfunction

        task report(input string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            error_count++;
        endtask

        task check_result(input logic [7:0] c, input logic [1:0] st);
            cipher_out_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result char_out %02h status %0d", c, st));
                return;
            end
            want = expected_q.pop_front();
            if (c !== want.char_val)
                report($sformatf("char_out %02h, expected %02h", c, want.char_val));
            if (st !== want.status_val)
                report($sformatf("status %0d, expected %0d", st, want.status_val));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            req_type;
    logic [7:0]            char_in;
    logic                  result_valid;
    logic [7:0]            char_out;
    logic [1:0]            status;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    cipher_scoreboard sb;
    int unsigned      items_sent;
    int unsigned      sender_idle_pct;
    int unsigned      quiet_cycles;

    keyword_substitution_cipher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .char_in      (char_in),
        .result_valid (result_valid),
        .char_out     (char_out),
        .status       (status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // monitor: results first, then the item taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                sb.check_result(char_out, status);
            if (start && !busy)
                sb.take_item(req_t'(req_type), char_in);
            if (psel && penable && pready && pwrite)
                sb.write_register(paddr, pwdata);
            if (psel && penable && pready && !pwrite
                && prdata !== CFG_DATA_W'(sb.min_distinct))
                sb.report($sformatf("prdata %0h, expected %0h", prdata, sb.min_distinct));
        end
        if (rst_n && ((start && !busy) || result_valid || (psel && penable && pready)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic idle_for(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_item(input req_t req, input logic [7:0] c);
        // idle cycle by cycle so the idle share matches the percentage
        while ($urandom_range(0, 99) < sender_idle_pct)
            idle_for(1);
        start    <= 1'b1;
        req_type <= req;
        char_in  <= c;
        do
            @(posedge clk);
        while (busy);
        // non-letter key bytes are dropped by the block
        if (req != REQ_KEY_CHAR || ((c | 8'h20) >= LOWER_A && (c | 8'h20) <= LOWER_Z))
            items_sent++;
    endtask

    task automatic wait_results_drained();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= MIN_DISTINCT_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_min_distinct(input logic [4:0] value);
        logic [CFG_DATA_W-1:0] data;
        data      = $urandom();
        data[4:0] = value;
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        apb_access(1'b1, data);
        apb_access(1'b0, '0);
    endtask

    task automatic send_key_text(input string s);
        foreach (s[i])
            send_item(REQ_KEY_CHAR, s[i]);
    endtask

    function automatic logic [7:0] random_letter();
        logic [7:0] c;
        c = LETTER_A + 8'($urandom_range(0, ALPHA_LEN - 1));
        if ($urandom_range(0, 1))
            c = c + 8'd32;
        return c;
    endfunction

    task automatic send_random_key();
        int unsigned order[ALPHA_LEN];
        int unsigned j;
        int unsigned tmp;
        int unsigned len;
        if ($urandom_range(0, 3) == 0)
        begin
            // whole alphabet in random order, with a few repeats
            foreach (order[i])
                order[i] = i;
            for (int i = ALPHA_LEN - 1; i > 0; i--)
            begin
                j        = $urandom_range(0, i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            foreach (order[i])
            begin
                send_item(REQ_KEY_CHAR, LETTER_A + 8'(order[i]) + ($urandom_range(0, 1) ? 8'd32 : 8'd0));
                if ($urandom_range(0, 9) == 0)
                    send_item(REQ_KEY_CHAR, random_letter());
            end
        end
        else
        begin
            len = $urandom_range(0, 20);
            repeat (len)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_item(REQ_KEY_CHAR, 8'($urandom()));
                else
                    send_item(REQ_KEY_CHAR, random_letter());
            end
        end
    endtask

    task automatic send_plaintext();
        int unsigned len;
        int unsigned pick;
        len = $urandom_range(1, 12);
        repeat (len)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_item(REQ_PLAIN, LETTER_A + 8'($urandom_range(0, ALPHA_LEN - 1)));
            else if (pick < 85)
                send_item(REQ_PLAIN, LOWER_A + 8'($urandom_range(0, ALPHA_LEN - 1)));
            else
                send_item(REQ_PLAIN, 8'($urandom()));
        end
    endtask

    task automatic run_phase(input int unsigned idle_pct, input int unsigned count);
        int unsigned stop_at;
        int unsigned pick;
        sender_idle_pct = idle_pct;
        stop_at         = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                send_random_key();
                send_item(REQ_KEY_END, 8'($urandom()));
                if ($urandom_range(0, 6) == 0)
                    send_item(REQ_KEY_END, 8'($urandom()));
                send_plaintext();
            end
            else if (pick < 78)
                send_plaintext();
            else if (pick < 86)
            begin
                send_random_key();
                send_item(REQ_CLEAR, 8'($urandom()));
                send_plaintext();
            end
            else if (pick < 95)
            begin
                repeat ($urandom_range(1, 6))
                    send_item(req_t'($urandom_range(0, 3)), 8'($urandom()));
            end
            else
                wait_results_drained();
        end
    endtask

    initial
    begin
        sb              = new();
        items_sent      = 0;
        sender_idle_pct = 0;
        quiet_cycles    = 0;
        rst_n    <= 1'b0;
        start    <= 1'b0;
        req_type <= REQ_KEY_CHAR;
        char_in  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no key yet, then an empty key below the reset minimum
        send_item(REQ_PLAIN, "A");
        send_item(REQ_KEY_END, 8'h00);
        send_item(REQ_KEY_END, 8'hFF);
        send_item(REQ_PLAIN, 8'hFF);
        // non-letters around both letter ranges, mixed case and a repeat
        send_item(REQ_KEY_CHAR, 8'hFF);
        send_item(REQ_KEY_CHAR, 8'h40);
        send_item(REQ_KEY_CHAR, 8'h5B);
        send_item(REQ_KEY_CHAR, 8'h60);
        send_item(REQ_KEY_CHAR, 8'h7B);
        send_key_text("zaZQkeyword");
        send_item(REQ_KEY_END, 8'h00);
        send_item(REQ_PLAIN, "A");
        send_item(REQ_PLAIN, "Z");
        send_item(REQ_PLAIN, "a");
        send_item(REQ_PLAIN, 8'h00);
        // key char after key end starts over, clear drops the key
        send_item(REQ_KEY_CHAR, "M");
        send_item(REQ_CLEAR, 8'h00);
        send_item(REQ_PLAIN, "B");

        for (int unsigned phase = 0; phase < 9; phase++)
        begin
            case (phase)
                0: set_min_distinct(5'd0);
                1: set_min_distinct(5'd31);
                2: set_min_distinct(5'd26);
                3: set_min_distinct(5'd1);
                4: set_min_distinct(5'd27);
                5: set_min_distinct(MIN_DISTINCT_RESET);
                6: set_min_distinct(5'd25);
                default: set_min_distinct(5'($urandom_range(0, 31)));
            endcase
            run_phase((phase < 3) ? 17 : (phase < 6) ? 73 : 0, PHASE_ITEMS);
        end

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
        if (sb.error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/kwsc_pkg.sv
rtl/core/kwsc_regs.sv
rtl/core/kwsc_ctrl.sv
rtl/core/kwsc_dp.sv
rtl/core/keyword_substitution_cipher.sv
rtl/core/kwsc_checker.sv
verif/tb_keyword_substitution_cipher.sv
